// ===== hdl/lra_pkg.sv =====
// Package for the line record assembler: control codes, sequencer states and
// the result word layout. No dependencies.
package lra_pkg;

  localparam logic [7:0] BYTE_CR   = 8'd13;
  localparam logic [7:0] BYTE_LF   = 8'd10;
  localparam logic [7:0] BYTE_INTR = 8'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } lra_state_e;

  // One result word as it sits in the output register.
  typedef struct packed {
    logic       overflow_error;
    logic       interrupt_record;
    logic       last_of_record;
    logic [7:0] out_byte;
  } lra_item_t;

endpackage

// ===== hdl/lra_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module lra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/line_record_assembler_unit.sv =====
// Line record assembler: top level. Uses lra_pkg for codes and states and
// lra_ram for the line buffer.
//
// The slave stream takes one received byte per word. CR or LF closes a line;
// a non-empty line then leaves on the master stream as a burst of its bytes
// in arrival order, with tlast on the final one. An empty line gives nothing.
// A line longer than LINE_BYTES is dropped and its terminator gives a single
// word with the overflow flag in tuser and zero data. Byte 3 at the start of
// a line leaves at once as a one-word interrupt record (tlast set).
// Throughput: ordinary data bytes are taken one per cycle while the output
// register is free. A terminator that releases a non-empty line holds tready
// low while the buffer is read back, since each byte passes a RAM read state
// and then a state that loads the output register. Interrupt and overflow
// words appear on the master side in the cycle after the input word is accepted.
// A result sits in the output register until it is taken; while it is held,
// tready stays low, so a stalled receiver stops the input side in turn.
// Reset clears the line count, the drop flag and the output valid; the
// buffer contents are not cleared and need no sweep.
module line_record_assembler_unit
  import lra_pkg::*;
#(
  parameter int LINE_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic [1:0] m_axis_tuser_o    // [0] interrupt_record, [1] overflow_error
);

  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int FW = $clog2(LINE_BYTES + 1);
  localparam logic [FW-1:0] CAP = FW'(LINE_BYTES);

  lra_state_e    state_q, state_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          drop_q, drop_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          out_valid_q, out_valid_d;
  lra_item_t     out_item_q, out_item_d;

  logic          in_fire;
  logic          out_free;
  logic          is_term;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic          rd_last;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_term         = (s_axis_tdata_i == BYTE_CR) || (s_axis_tdata_i == BYTE_LF);
  assign rd_last         = (FW'(rd_idx_q) + FW'(1)) == fill_q;

  lra_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[AW-1:0]),
    .wdata_i (s_axis_tdata_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && is_term && !drop_q && (fill_q != '0)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = rd_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    fill_d      = fill_q;
    drop_d      = drop_q;
    rd_idx_d    = rd_idx_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      ST_IDLE: begin
        rd_idx_d = '0;
        if (in_fire) begin
          if (is_term) begin
            if (drop_q) begin
              drop_d      = 1'b0;
              fill_d      = '0;
              out_valid_d = 1'b1;
              out_item_d  = '{overflow_error: 1'b1, interrupt_record: 1'b0,
                              last_of_record: 1'b0, out_byte: 8'd0};
            end
          end else if ((s_axis_tdata_i == BYTE_INTR) && (fill_q == '0)) begin
            out_valid_d = 1'b1;
            out_item_d  = '{overflow_error: 1'b0, interrupt_record: 1'b1,
                            last_of_record: 1'b1, out_byte: s_axis_tdata_i};
          end else if (!drop_q) begin
            if (fill_q == CAP) begin
              drop_d = 1'b1;
            end else begin
              ram_we = 1'b1;
              fill_d = fill_q + FW'(1);
            end
          end
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_item_d  = '{overflow_error: 1'b0, interrupt_record: 1'b0,
                          last_of_record: rd_last, out_byte: ram_rdata};
          if (rd_last) begin
            fill_d = '0;
          end else begin
            rd_idx_d = rd_idx_q + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      drop_q      <= 1'b0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      drop_q      <= drop_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_item_q.out_byte;
  assign m_axis_tlast_o  = out_item_q.last_of_record;
  assign m_axis_tuser_o  = {out_item_q.overflow_error, out_item_q.interrupt_record};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CAP)
    else $error("line count exceeds buffer size");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q |-> (fill_q == CAP))
    else $error("drop flag set with buffer not full");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ((fill_q != '0) && !drop_q && !s_axis_tready_o))
    else $error("readback running on an empty or dropped line");

  a_drain_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (FW'(rd_idx_q) < fill_q))
    else $error("readback index beyond line length");

endmodule
